[sv/lookahead_waypoint_follower_top_defines.svh]
// Assertion macros shared by the RTL.
`ifndef LOOKAHEAD_WAYPOINT_FOLLOWER_TOP_DEFINES_SVH
`define LOOKAHEAD_WAYPOINT_FOLLOWER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent in the same cycle
`define LWF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent holds -> consequent in the next cycle
`define LWF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LWF_ASSERT_IMP(label, ante, cons, msg)
`define LWF_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[sv/lwf_pkg.sv]
package lwf_pkg;

    localparam int DIST_W = 64;
    localparam int ROOT_W = 32;
    localparam int ACC_W  = 24;
    localparam logic [ACC_W-1:0] ACC_MAX = 24'hFF_FFFF;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_UPDATE  = 2'd2;

    localparam logic REG_PATH_LENGTH = 1'b0;
    localparam logic REG_LOOKAHEAD   = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] radicand;
    } sq_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sq_rsp_t;

endpackage

[sv/lwf_isqrt.sv]
module lwf_isqrt
(
    input  logic             clk,
    input  logic             rst_n,
    input  lwf_pkg::sq_req_t req,
    output lwf_pkg::sq_rsp_t rsp
);
    import lwf_pkg::*;

    logic [DIST_W-1:0] v_reg, v_next;
    logic [DIST_W-1:0] res_reg, res_next;
    logic [DIST_W-1:0] bit_reg, bit_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIST_W-1:0] trial;

    // one result bit per cycle
    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (req.start)
        begin
            v_next    = req.radicand;
            res_next  = '0;
            bit_next  = DIST_W'(1) << (DIST_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == DIST_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[ROOT_W-1:0];

endmodule

[sv/lookahead_waypoint_follower_top.sv]
// Lookahead waypoint follower. Waypoints are written into a store by index;
// a restart or a position update moves the nearest index and then walks
// segment lengths forward until the lookahead distance is covered or the path
// ends, reporting target and nearest. Every input item gives one result item.
// The block takes one item at a time. A waypoint write or an unknown action
// puts its result out in the cycle after the item is taken. A distance uses
// one shared multiplier, one axis at a time, for each candidate the nearest
// search reads. Each walked segment also runs the bit-serial square root
// before the walk moves on to the next waypoint. The store has no reset;
// every waypoint the path uses must be written first.
`include "lookahead_waypoint_follower_top_defines.svh"

module lookahead_waypoint_follower_top
#(
    parameter int MAX_WAYPOINTS = 1024,
    parameter int COORD_BITS    = 24
)
(
    input  logic clk,
    input  logic rst_n,
    // action, waypoint_index, coord_x, coord_y, coord_z (low bit up)
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((12 + 3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // target_waypoint, nearest_waypoint (low bit up)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata
);
    import lwf_pkg::*;

    localparam int IDX_W  = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W  = $clog2(MAX_WAYPOINTS + 1);
    localparam int LOOP_W = CNT_W + 1;
    localparam int WP_W   = 3 * COORD_BITS;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SUMX_W = (SUM_W > 65) ? SUM_W : 65;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_RD     = 12'b000000000010,
        S_WAIT   = 12'b000000000100,
        S_MUL    = 12'b000000001000,
        S_ACC    = 12'b000000010000,
        S_DIST   = 12'b000000100000,
        S_SQRT   = 12'b000001000000,
        S_CAND   = 12'b000010000000,
        S_LOOP   = 12'b000100000000,
        S_TSTART = 12'b001000000000,
        S_TCHK   = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    typedef enum logic [3:0] {
        P_NEAR0 = 4'b0001,
        P_NEARC = 4'b0010,
        P_TGT0  = 4'b0100,
        P_TGT   = 4'b1000
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [10:0]      path_length_reg, path_length_next;
    logic [ACC_W-1:0] lookahead_reg, lookahead_next;
    logic [IDX_W-1:0] nearest_reg, nearest_next;
    logic [IDX_W-1:0] target_reg, target_next;

    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic [DIST_W-1:0] cand_d_reg, cand_d_next;
    logic [LOOP_W-1:0] cand_reg, cand_next;
    logic [1:0]        checked_reg, checked_next;
    logic [LOOP_W-1:0] walk_reg, walk_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [WP_W-1:0]   a_reg, a_next;
    logic [1:0]        k_reg, k_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    logic [WP_W-1:0] mem [MAX_WAYPOINTS];
    logic [WP_W-1:0] rd_data_reg;

    logic [1:0]            in_action;
    logic [9:0]            in_slot;
    logic [WP_W-1:0]       in_point;
    logic [CNT_W-1:0]      len;
    logic                  accept;
    logic                  wr_en;
    logic [COORD_BITS-1:0] a_c, b_c;
    logic [DIFF_W-1:0]     diff, mag;
    logic [SUMX_W-1:0]     sum_x;
    logic [DIST_W-1:0]     dist_sat;
    logic [ACC_W-1:0]      acc_sum;
    logic [ROOT_W:0]       seg_sum;
    logic [LOOP_W-1:0]     cand_inc;
    logic [1:0]            checked_inc;
    logic                  keep_going;
    sq_req_t               sq_req;
    sq_rsp_t               sq_rsp;

    assign in_action = s_tdata[1:0];
    assign in_slot   = s_tdata[11:2];
    assign in_point  = s_tdata[12 +: WP_W];
    assign accept    = s_tvalid && s_tready;
    assign wr_en     = accept && (in_action == ACT_WRITE)
                       && (32'(in_slot) < 32'(MAX_WAYPOINTS));

    always_comb
    begin
        if (path_length_reg == 11'd0)
            len = CNT_W'(1);
        else if (32'(path_length_reg) > 32'(MAX_WAYPOINTS))
            len = CNT_W'(MAX_WAYPOINTS);
        else
            len = CNT_W'(path_length_reg);
    end

    // shared distance datapath: one axis per pass
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                a_c = a_reg[0 +: COORD_BITS];
                b_c = rd_data_reg[0 +: COORD_BITS];
            end
            2'd1:
            begin
                a_c = a_reg[COORD_BITS +: COORD_BITS];
                b_c = rd_data_reg[COORD_BITS +: COORD_BITS];
            end
            default:
            begin
                a_c = a_reg[2 * COORD_BITS +: COORD_BITS];
                b_c = rd_data_reg[2 * COORD_BITS +: COORD_BITS];
            end
        endcase
        diff  = {a_c[COORD_BITS-1], a_c} - {b_c[COORD_BITS-1], b_c};
        mag   = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        sum_x = SUMX_W'(sum_reg);
        if (sum_x > SUMX_W'(64'hFFFF_FFFF_FFFF_FFFF))
            dist_sat = '1;
        else
            dist_sat = sum_x[DIST_W-1:0];
    end

    assign seg_sum     = {{(ROOT_W - ACC_W + 1){1'b0}}, acc_reg} + {1'b0, sq_rsp.root};
    assign acc_sum     = (seg_sum > (ROOT_W + 1)'(ACC_MAX)) ? ACC_MAX
                                                            : seg_sum[ACC_W-1:0];
    assign cand_inc    = cand_reg + LOOP_W'(1);
    assign checked_inc = (checked_reg == 2'd3) ? 2'd3 : checked_reg + 2'd1;
    assign keep_going  = ((cand_inc < LOOP_W'(len)) && (cand_d_reg <= best_d_reg))
                         || (checked_inc < 2'd2);

    assign sq_req.start    = (state_reg == S_DIST) && (phase_reg == P_TGT);
    assign sq_req.radicand = dist_sat;

    lwf_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        path_length_next = path_length_reg;
        lookahead_next   = lookahead_reg;
        nearest_next     = nearest_reg;
        target_next      = target_reg;
        cur_next         = cur_reg;
        best_next        = best_reg;
        best_d_next      = best_d_reg;
        cand_d_next      = cand_d_reg;
        cand_next        = cand_reg;
        checked_next     = checked_reg;
        walk_next        = walk_reg;
        acc_next         = acc_reg;
        rd_idx_next      = rd_idx_reg;
        a_next           = a_reg;
        k_next           = k_reg;
        prod_next        = prod_reg;
        sum_next         = sum_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PATH_LENGTH: path_length_next = cfg_wdata[10:0];
                REG_LOOKAHEAD:   lookahead_next   = cfg_wdata;
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_action)
                        ACT_RESTART:
                        begin
                            nearest_next = '0;
                            state_next   = S_TSTART;
                        end
                        ACT_UPDATE:
                        begin
                            if (CNT_W'(nearest_reg) > len - CNT_W'(1))
                                cur_next = IDX_W'(len - CNT_W'(1));
                            else
                                cur_next = nearest_reg;
                            nearest_next = cur_next;
                            rd_idx_next  = cur_next;
                            a_next       = in_point;
                            phase_next   = P_NEAR0;
                            state_next   = S_RD;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_RD:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (phase_reg == P_TGT0)
                begin
                    a_next     = rd_data_reg;
                    state_next = S_TCHK;
                end
                else
                begin
                    k_next     = 2'd0;
                    sum_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = mag * mag;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = sum_reg + SUM_W'(prod_reg);
                if (k_reg == 2'd2)
                    state_next = S_DIST;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DIST:
            begin
                case (phase_reg)
                    P_NEAR0:
                    begin
                        best_d_next  = dist_sat;
                        cand_d_next  = dist_sat;
                        best_next    = cur_reg;
                        cand_next    = LOOP_W'(cur_reg) + LOOP_W'(1);
                        checked_next = 2'd0;
                        state_next   = S_CAND;
                    end
                    P_NEARC:
                    begin
                        cand_d_next = dist_sat;
                        if (dist_sat <= best_d_reg)
                        begin
                            best_next   = cand_reg[IDX_W-1:0];
                            best_d_next = dist_sat;
                        end
                        state_next = S_LOOP;
                    end
                    default: state_next = S_SQRT;
                endcase
            end
            S_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    acc_next   = acc_sum;
                    a_next     = rd_data_reg;
                    walk_next  = walk_reg + LOOP_W'(1);
                    state_next = S_TCHK;
                end
            end
            S_CAND:
            begin
                if (cand_reg < LOOP_W'(len))
                begin
                    rd_idx_next = cand_reg[IDX_W-1:0];
                    phase_next  = P_NEARC;
                    state_next  = S_RD;
                end
                else
                    state_next = S_LOOP;
            end
            S_LOOP:
            begin
                cand_next    = cand_inc;
                checked_next = checked_inc;
                if (keep_going)
                    state_next = S_CAND;
                else
                begin
                    if (best_reg != cur_reg)
                        nearest_next = best_reg;
                    else if (LOOP_W'(cur_reg) + LOOP_W'(1) < LOOP_W'(len))
                        nearest_next = cur_reg + IDX_W'(1);
                    state_next = S_TSTART;
                end
            end
            S_TSTART:
            begin
                walk_next   = LOOP_W'(nearest_reg);
                acc_next    = '0;
                rd_idx_next = nearest_reg;
                phase_next  = P_TGT0;
                state_next  = S_RD;
            end
            S_TCHK:
            begin
                if ((walk_reg < LOOP_W'(len)) && (acc_reg < lookahead_reg))
                begin
                    rd_idx_next = walk_reg[IDX_W-1:0];
                    phase_next  = P_TGT;
                    state_next  = S_RD;
                end
                else
                begin
                    if (walk_reg == LOOP_W'(nearest_reg))
                        target_next = nearest_reg;
                    else
                        target_next = IDX_W'(walk_reg - LOOP_W'(1));
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= P_NEAR0;
            path_length_reg <= 11'd1;
            lookahead_reg   <= 24'd256;
            nearest_reg     <= '0;
            target_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            path_length_reg <= path_length_next;
            lookahead_reg   <= lookahead_next;
            nearest_reg     <= nearest_next;
            target_reg      <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        best_reg    <= best_next;
        best_d_reg  <= best_d_next;
        cand_d_reg  <= cand_d_next;
        cand_reg    <= cand_next;
        checked_reg <= checked_next;
        walk_reg    <= walk_next;
        acc_reg     <= acc_next;
        rd_idx_reg  <= rd_idx_next;
        a_reg       <= a_next;
        k_reg       <= k_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
    end

    // waypoint store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[IDX_W'(in_slot)] <= in_point;
        if (state_reg == S_RD)
            rd_data_reg <= mem[rd_idx_reg];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {4'd0, 10'(nearest_reg), 10'(target_reg)};

    `LWF_ASSERT_IMP(a_no_overlap, s_tready, !m_tvalid, "input and output open together")
    `LWF_ASSERT_IMP(a_target_ahead, m_tvalid, target_reg >= nearest_reg,
                    "target behind nearest")
    `LWF_ASSERT_IMP(a_root_in_walk, sq_rsp.done, state_reg == S_SQRT,
                    "square root finished outside a segment walk")
    `LWF_ASSERT_NXT(a_ready_after_out, m_tvalid && m_tready, s_tready,
                    "not ready after result taken")

endmodule

[bench/lookahead_waypoint_follower_checker.sv]
module lookahead_waypoint_follower_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata,
    output int          errors,
    output int          pending
);
    import lwf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [9:0] target;
        logic [9:0] nearest;
    } follow_res_t;

    logic signed [23:0] wpx [1024];
    logic signed [23:0] wpy [1024];
    logic signed [23:0] wpz [1024];
    logic [9:0]         near_idx;
    logic [9:0]         tgt_idx;
    logic [10:0]        path_len;
    logic [23:0]        look_dist;
    follow_res_t        expected_q [$];
    int                 mism;

    function automatic longint unsigned dist_sq(int ax, int ay, int az, int bx, int by, int bz);
        longint dx, dy, dz;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        dz = longint'(az) - longint'(bz);
        return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned seg_dist(int a, int b);
        return dist_sq(wpx[a], wpy[a], wpz[a], wpx[b], wpy[b], wpz[b]);
    endfunction

    function automatic longint unsigned pos_dist(int px, int py, int pz, int k);
        return dist_sq(px, py, pz, wpx[k], wpy[k], wpz[k]);
    endfunction

    task automatic walk_target(int len);
        int i, prev;
        longint unsigned acc;
        i = near_idx;
        prev = near_idx;
        acc = 0;
        while (i < len && acc < look_dist)
        begin
            acc = acc + int_root(seg_dist(prev, i));
            if (acc > ACC_MAX)
                acc = ACC_MAX;
            prev = i;
            i++;
        end
        tgt_idx = (i == near_idx) ? near_idx : 10'(i - 1);
    endtask

    task automatic track_nearest(int px, int py, int pz, int len);
        int cur, cand, best, checked;
        longint unsigned best_d, cand_d;
        if (near_idx > len - 1)
            near_idx = 10'(len - 1);
        cur = near_idx;
        best = cur;
        best_d = pos_dist(px, py, pz, cur);
        cand_d = best_d;
        cand = cur + 1;
        checked = 0;
        do
        begin
            if (cand < len)
            begin
                cand_d = pos_dist(px, py, pz, cand);
                if (cand_d <= best_d)
                begin
                    best = cand;
                    best_d = cand_d;
                end
            end
            cand++;
            checked++;
        end
        while ((cand < len && cand_d <= best_d) || checked < 2);
        if (best != cur)
            near_idx = 10'(best);
        else if (cur + 1 < len)
            near_idx = 10'(cur + 1);
    endtask

    task automatic apply_item(logic [87:0] d);
        logic [1:0] act;
        int len;
        act = d[1:0];
        len = (path_len == 0) ? 1 : (path_len > 1024) ? 1024 : int'(path_len);
        if (act == ACT_WRITE)
        begin
            wpx[d[11:2]] = d[35:12];
            wpy[d[11:2]] = d[59:36];
            wpz[d[11:2]] = d[83:60];
        end
        else if (act == ACT_RESTART)
        begin
            near_idx = '0;
            walk_target(len);
        end
        else if (act == ACT_UPDATE)
        begin
            track_nearest(int'($signed(d[35:12])), int'($signed(d[59:36])),
                          int'($signed(d[83:60])), len);
            walk_target(len);
        end
        expected_q.push_back('{target: tgt_idx, nearest: near_idx});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_idx  = '0;
            tgt_idx   = '0;
            path_len  = 11'd1;
            look_dist = 24'd256;
            errors    <= 0;
            pending   <= 0;
            expected_q.delete();
        end
        else
        begin
            mism = 0;
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                    mism++;
                end
                else
                begin
                    follow_res_t e;
                    e = expected_q.pop_front();
                    if (m_tdata[9:0] !== e.target)
                    begin
                        $display("%0t: target_waypoint expected %0d got %0d",
                                 $time, e.target, m_tdata[9:0]);
                        mism++;
                    end
                    if (m_tdata[19:10] !== e.nearest)
                    begin
                        $display("%0t: nearest_waypoint expected %0d got %0d",
                                 $time, e.nearest, m_tdata[19:10]);
                        mism++;
                    end
                end
            end
            errors <= errors + mism;
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_PATH_LENGTH)
                    path_len = cfg_wdata[10:0];
                else
                    look_dist = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                apply_item(s_tdata);
            pending <= expected_q.size();
        end
    end
endmodule

[bench/lookahead_waypoint_follower_top_tb.sv]
module lookahead_waypoint_follower_top_tb;
    import lwf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 4000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_PATH_LENGTH;
    logic [23:0] cfg_wdata = '0;
    int          errors;
    int          pending;
    int          cyc = 0;
    int          burst_left = 0;
    int          ready_pct = 100;
    bit          written [1024];
    int          cur_len = 1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    lookahead_waypoint_follower_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    lookahead_waypoint_follower_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    // receiver: random stalls; the stall rate changes on the cyc counter
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 300 == 0)
            ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(15, 90);
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
        if (cyc == RUN_LIMIT)
        begin
            $display("[lookahead_waypoint_follower_top] ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] act, logic [9:0] slot, int x, int y, int z);
        bit taken;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if (act == ACT_WRITE)
            written[slot] = 1'b1;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, z[23:0], y[23:0], x[23:0], slot, act};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regs(int plen, int ladist);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PATH_LENGTH;
        cfg_wdata <= 24'(plen);
        @(posedge clk);
        cfg_index <= REG_LOOKAHEAD;
        cfg_wdata <= 24'(ladist);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_len = (plen == 0) ? 1 : (plen > 1024) ? 1024 : plen;
    endtask

    function automatic int noise(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic write_track(int slot);
        send_item(ACT_WRITE, 10'(slot), slot * 512 + noise(150), noise(300), noise(60));
    endtask

    task automatic fill_path();
        for (int i = 0; i < cur_len; i++)
            if (!written[i])
                write_track(i);
    endtask

    task automatic random_phase(int count);
        int r, k;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, cur_len - 1);
            if (r < 12)
                write_track($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : k);
            else if (r < 15)
                send_item(ACT_WRITE, 10'($urandom), $urandom, $urandom, $urandom);
            else if (r < 22)
                send_item(ACT_RESTART, 10'($urandom), $urandom, $urandom, $urandom);
            else if (r < 26)
                send_item(2'd3, 10'($urandom), $urandom, $urandom, $urandom);
            else if (r < 30)
                send_item(ACT_UPDATE, 10'($urandom), $urandom, $urandom, $urandom);
            else
                send_item(ACT_UPDATE, 10'($urandom), k * 512 + noise(600), noise(800),
                          noise(200));
        end
    endtask

    initial
    begin
        // the full-length path fill alone is close to a thousand writes
        int lens [10] = '{1, 2, 3, 16, 40, 64, 1024, 2047, 0, 33};
        int dists [10] = '{256, 1, 3000, 700, 16777215, 12000, 2000, 16777215, 0, 8388608};
        int counts [10] = '{8, 8, 12, 18, 18, 26, 16, 4, 8, 12};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: extremes, unknown action, zero/short paths, clamp and end-of-path cases
        send_item(ACT_WRITE, 10'd0, -8388608, 8388607, -1);
        send_item(ACT_WRITE, 10'd1, 8388607, -8388608, 0);
        send_item(ACT_WRITE, 10'd1023, 8388607, 8388607, -8388608);
        send_item(2'd3, 10'd1023, -1, -1, -1);
        send_item(ACT_RESTART, 10'd0, 0, 0, 0);
        send_item(ACT_UPDATE, 10'd0, 8388607, -8388608, 8388607);
        set_regs(0, 0);
        send_item(ACT_RESTART, 10'd0, 0, 0, 0);
        send_item(ACT_UPDATE, 10'd0, -8388608, -8388608, -8388608);
        send_item(ACT_WRITE, 10'd2, 0, 0, 0);
        set_regs(3, 16777215);
        send_item(ACT_RESTART, 10'd0, 0, 0, 0);
        send_item(ACT_UPDATE, 10'd0, 0, 0, 0);
        send_item(ACT_UPDATE, 10'd0, 0, 0, 0);
        send_item(ACT_UPDATE, 10'd0, 0, 0, 0);
        set_regs(2, 1);
        send_item(ACT_UPDATE, 10'd0, 8388607, -8388608, 0);
        send_item(ACT_RESTART, 10'd0, 0, 0, 0);

        for (int p = 0; p < 10; p++)
        begin
            set_regs(lens[p], dists[p]);
            fill_path();
            random_phase(counts[p] / 2);
            // hold off until the block has answered everything
            drain();
            random_phase(counts[p] - counts[p] / 2);
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[lookahead_waypoint_follower_top] OK");
        else
            $display("[lookahead_waypoint_follower_top] ERROR");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/lwf_pkg.sv
sv/lwf_isqrt.sv
sv/lookahead_waypoint_follower_top.sv
bench/lookahead_waypoint_follower_checker.sv
bench/lookahead_waypoint_follower_top_tb.sv
